>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `ASSERT_CLK(lbl, clk, rst_n, !(cond), msg)

`endif

>>> hw/rtl/uedr_pkg.sv
// ----------------------------------------------------------------------------
// uedr_pkg
// Types, constants and tables of the unicycle dead reckoning block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package uedr_pkg;

  localparam int CordicStepsDef = 16;
  localparam int AtanLen        = 24;
  localparam int IterW          = $clog2(AtanLen);
  localparam int XyW            = 34;   // Q2.30 plus guard bit
  localparam int ZW             = 33;   // 2^32 per turn, signed
  localparam int MulAW          = 34;
  localparam int MulBW          = 17;
  localparam int ProdW          = MulAW + MulBW;
  localparam int AccW           = 64;

  localparam logic signed [XyW-1:0] InvGain = 34'sd652032874;

  // 65536/(2*pi) in Q.16 split into two 15-bit halves
  localparam logic [14:0] RadBamLo = 15'd24796;
  localparam logic [14:0] RadBamHi = 15'd20860;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC,
    ST_MUL_C,
    ST_MUL_S,
    ST_MUL_R,
    ST_MUL_KL,
    ST_MUL_KH,
    ST_ACC,
    ST_HEAD,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    CFG_STEP_TIME     = 2'd0,
    CFG_START_X       = 2'd1,
    CFG_START_Y       = 2'd2,
    CFG_START_HEADING = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        start;
    logic [15:0] bam;
  } cordic_req_t;

  typedef struct packed {
    logic                  done;
    logic signed [XyW-1:0] cos_v;
    logic signed [XyW-1:0] sin_v;
  } cordic_rsp_t;

  // atan(2^-i), 2^32 per turn
  function automatic logic [29:0] atan_lookup(input logic [IterW-1:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:    v = 30'd536870912;
      5'd1:    v = 30'd316933406;
      5'd2:    v = 30'd167458907;
      5'd3:    v = 30'd85004756;
      5'd4:    v = 30'd42667331;
      5'd5:    v = 30'd21354465;
      5'd6:    v = 30'd10679838;
      5'd7:    v = 30'd5340245;
      5'd8:    v = 30'd2670163;
      5'd9:    v = 30'd1335087;
      5'd10:   v = 30'd667544;
      5'd11:   v = 30'd333772;
      5'd12:   v = 30'd166886;
      5'd13:   v = 30'd83443;
      5'd14:   v = 30'd41722;
      5'd15:   v = 30'd20861;
      5'd16:   v = 30'd10430;
      5'd17:   v = 30'd5215;
      5'd18:   v = 30'd2608;
      5'd19:   v = 30'd1304;
      5'd20:   v = 30'd652;
      5'd21:   v = 30'd326;
      5'd22:   v = 30'd163;
      5'd23:   v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/unicycle_euler_dead_reckoning.sv
// ----------------------------------------------------------------------------
// unicycle_euler_dead_reckoning
// One explicit Euler step of a unit-speed unicycle per input word.
// ----------------------------------------------------------------------------
// A step runs the iterative CORDIC, min(CordicSteps, 24) iterations, followed
// by five passes through one multiplier; s_axis_tready is low while a step
// runs, so a new word is taken only after the previous step has handed its
// pose to the output register.
// A finished pose waits in the output register while the next word is taken.
// Reset (async, active low): pose cleared, step_time 0.5 s, start pose zero.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module unicycle_euler_dead_reckoning import uedr_pkg::*; #(
  parameter int CordicSteps = CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] turn_rate
  input  logic        s_axis_tuser,   // [0] restart
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // [31:0] pos_x, [63:32] pos_y, [79:64] heading
  output logic        m_axis_tuser    // [0] saturated
);

  state_e state_q, state_d;

  logic [15:0]        step_time_q;
  logic signed [31:0] start_x_q, start_y_q;
  logic [15:0]        start_heading_q;

  logic signed [31:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [15:0]        cur_heading_q, cur_heading_d;
  logic               clip_q, clip_d;
  logic signed [15:0] rate_q;

  logic signed [ProdW-1:0] p_q;
  logic signed [32:0]      prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d;

  logic               out_valid_q, out_valid_d;
  logic [79:0]        out_data_q;
  logic               out_sat_q;

  logic               in_acc;
  logic               out_load;
  cordic_req_t        creq;
  cordic_rsp_t        crsp;

  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;

  logic signed [ProdW-1:0] disp_r;
  logic signed [20:0]      delta;
  logic signed [31:0]      sat_base;
  logic signed [33:0]      sat_sum;
  logic signed [31:0]      sat_val;
  logic                    sat_clip;
  logic signed [AccW-1:0]  head_r;

  uedr_cordic #(
    .CordicSteps(CordicSteps)
  ) u_cordic (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (creq),
    .rsp_o (crsp)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (in_acc) state_d = ST_CORDIC;
      ST_CORDIC: if (crsp.done) state_d = ST_MUL_C;
      ST_MUL_C:  state_d = ST_MUL_S;
      ST_MUL_S:  state_d = ST_MUL_R;
      ST_MUL_R:  state_d = ST_MUL_KL;
      ST_MUL_KL: state_d = ST_MUL_KH;
      ST_MUL_KH: state_d = ST_ACC;
      ST_ACC:    state_d = ST_HEAD;
      ST_HEAD:   state_d = ST_DONE;
      ST_DONE:   if (out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs: CORDIC start and multiplier operands
  always_comb begin
    creq.start = in_acc;
    creq.bam   = s_axis_tuser ? start_heading_q : cur_heading_q;
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      ST_MUL_C: begin
        mul_a = crsp.cos_v;
        mul_b = MulBW'(signed'({1'b0, step_time_q}));
      end
      ST_MUL_S: begin
        mul_a = crsp.sin_v;
        mul_b = MulBW'(signed'({1'b0, step_time_q}));
      end
      ST_MUL_R: begin
        mul_a = MulAW'(rate_q);
        mul_b = MulBW'(signed'({1'b0, step_time_q}));
      end
      ST_MUL_KL: begin
        mul_a = MulAW'(signed'(p_q[32:0]));
        mul_b = MulBW'(signed'({1'b0, RadBamLo}));
      end
      ST_MUL_KH: begin
        mul_a = MulAW'(prod_q);
        mul_b = MulBW'(signed'({1'b0, RadBamHi}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // displacement: shift right by 30, round half away from zero
  assign disp_r   = p_q + ProdW'(signed'(33'sd536870912)) - ProdW'(p_q[ProdW-1]);
  assign delta    = disp_r[50:30];
  assign sat_base = (state_q == ST_MUL_S) ? cur_x_q : cur_y_q;
  assign sat_sum  = 34'(sat_base) + 34'(delta);
  always_comb begin
    sat_clip = (sat_sum[33:31] != 3'b000) && (sat_sum[33:31] != 3'b111);
    if (!sat_clip) begin
      sat_val = sat_sum[31:0];
    end else if (sat_sum[33]) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = 32'sh7fff_ffff;
    end
  end

  // heading increment: shift right by 44, round half away from zero
  assign head_r = acc_q + AccW'(64'sd8796093022208) - AccW'(acc_q[AccW-1]);

  always_comb begin
    cur_x_d       = cur_x_q;
    cur_y_d       = cur_y_q;
    cur_heading_d = cur_heading_q;
    clip_d        = clip_q;
    acc_d         = acc_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          clip_d = 1'b0;
          if (s_axis_tuser) begin
            cur_x_d       = start_x_q;
            cur_y_d       = start_y_q;
            cur_heading_d = start_heading_q;
          end
        end
      end
      ST_MUL_S: begin
        cur_x_d = sat_val;
        clip_d  = clip_q | sat_clip;
      end
      ST_MUL_R: begin
        cur_y_d = sat_val;
        clip_d  = clip_q | sat_clip;
      end
      ST_MUL_KH: acc_d = AccW'(p_q);
      ST_ACC:    acc_d = acc_q + (AccW'(p_q) <<< 15);
      ST_HEAD:   cur_heading_d = cur_heading_q + head_r[59:44];
      default:   cur_x_d = cur_x_q;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      step_time_q     <= 16'd32768;
      start_x_q       <= '0;
      start_y_q       <= '0;
      start_heading_q <= '0;
      cur_x_q         <= '0;
      cur_y_q         <= '0;
      cur_heading_q   <= '0;
      clip_q          <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q       <= state_d;
      cur_x_q       <= cur_x_d;
      cur_y_q       <= cur_y_d;
      cur_heading_q <= cur_heading_d;
      clip_q        <= clip_d;
      out_valid_q   <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_STEP_TIME:     step_time_q     <= cfg_data_i[15:0];
          CFG_START_X:       start_x_q       <= cfg_data_i;
          CFG_START_Y:       start_y_q       <= cfg_data_i;
          CFG_START_HEADING: start_heading_q <= cfg_data_i[15:0];
          default:           step_time_q     <= step_time_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p_q   <= mul_a * mul_b;
    acc_q <= acc_d;
    if (in_acc) begin
      rate_q <= s_axis_tdata;
    end
    if (state_q == ST_MUL_KL) begin
      prod_q <= p_q[32:0];
    end
    if (out_load) begin
      out_data_q <= {cur_heading_q, cur_y_q, cur_x_q};
      out_sat_q  <= clip_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

  `ASSERT_CLK(a_busy_after_accept, clk_i, rst_ni,
              in_acc |=> !s_axis_tready, "input taken while a step runs")
  `ASSERT_CLK(a_cordic_done_in_wait, clk_i, rst_ni,
              crsp.done |-> (state_q == ST_CORDIC), "CORDIC finished outside its wait")
  `ASSERT_CLK(a_result_holds_slot, clk_i, rst_ni,
              (state_q == ST_DONE && m_axis_tvalid && !m_axis_tready) |=>
              (state_q == ST_DONE), "pending result overwritten")

endmodule

>>> hw/rtl/uedr_cordic.sv
// ----------------------------------------------------------------------------
// uedr_cordic
// Iterative rotation-mode CORDIC: cosine and sine of a 16-bit binary angle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uedr_cordic import uedr_pkg::*; #(
  parameter int CordicSteps = CordicStepsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cordic_req_t req_i,
  output cordic_rsp_t rsp_o
);

  localparam int NumIter = (CordicSteps > AtanLen) ? AtanLen : CordicSteps;
  localparam logic [IterW-1:0] LastIter = IterW'(NumIter - 1);
  localparam logic signed [ZW-1:0] HalfPi = 33'sd1073741824;
  localparam logic signed [ZW-1:0] Pi     = 33'sd2147483648;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  flip_q, flip_d;
  logic [IterW-1:0]      iter_q, iter_d;
  logic signed [XyW-1:0] x_q, x_d, y_q, y_d;
  logic signed [ZW-1:0]  z_q, z_d;

  logic signed [ZW-1:0]  z_init;
  logic signed [ZW-1:0]  atan_v;
  logic signed [XyW-1:0] dx, dy;

  always_comb begin
    z_init = ZW'(signed'({req_i.bam, 16'h0000}));
    flip_d = flip_q;
    if (req_i.start) begin
      flip_d = 1'b0;
      if (z_init > HalfPi) begin
        z_init = z_init - Pi;
        flip_d = 1'b1;
      end else if (z_init < -HalfPi) begin
        z_init = z_init + Pi;
        flip_d = 1'b1;
      end
    end
  end

  assign atan_v = ZW'(signed'({1'b0, atan_lookup(iter_q)}));
  assign dx     = y_q >>> iter_q;
  assign dy     = x_q >>> iter_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      iter_d = '0;
      x_d    = InvGain;
      y_d    = '0;
      z_d    = z_init;
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_d = x_q - dx;
        y_d = y_q + dy;
        z_d = z_q - atan_v;
      end else begin
        x_d = x_q + dx;
        y_d = y_q - dy;
        z_d = z_q + atan_v;
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == LastIter) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  // fold back angles that were moved by half a turn
  assign rsp_o.done  = done_q;
  assign rsp_o.cos_v = flip_q ? -x_q : x_q;
  assign rsp_o.sin_v = flip_q ? -y_q : y_q;

endmodule
